// ===== rtl/huffman_bit_packer_assert.svh =====
// assertion macros shared by the bit packer modules
`ifndef HUFFMAN_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define HBP_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);
`define HBP_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define HBP_ASSERT(lbl, ck, rs, prop, msg)
`define HBP_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif

`endif

// ===== rtl/hbp_pkg.sv =====
// types and constants of the huffman bit packer
package hbp_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  localparam logic [1:0] REG_ZERO_SYM = 2'd0;
  localparam logic [1:0] REG_ONE_SYM  = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  localparam logic [31:0] HIGH_MARK    = 32'h8000_0000;
  localparam logic [4:0]  FIRST_FREE   = 5'd31;
  localparam int          OUT_DEPTH    = 4;
  localparam int          OUT_PTR_W    = $clog2(OUT_DEPTH);
  localparam int          OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [4:0] len;
    logic [7:0] code;
  } tbl_entry_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        word_valid;
    logic        last;
    logic [31:0] total_bytes;
    logic        overflow;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } pack_res_t;

endpackage

// ===== rtl/hbp_table.sv =====
// code length and code value table, one synchronous read port
module hbp_table #(
  parameter int SYMBOL_COUNT = 256,
  parameter int IDX_W = $clog2(SYMBOL_COUNT)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  hbp_pkg::tbl_entry_t wr_data,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_idx,
  output hbp_pkg::tbl_entry_t rd_data
);

  hbp_pkg::tbl_entry_t mem [SYMBOL_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// ===== rtl/hbp_pack.sv =====
// packing stage: shift-merge of codes, word emission and end rule
`include "huffman_bit_packer_assert.svh"

module hbp_pack (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                in_fin,
  input  logic [7:0]          in_sym,
  input  hbp_pkg::tbl_entry_t rd_data,
  input  logic                adv,
  input  logic [7:0]          zero_sym,
  input  logic [7:0]          one_sym,
  input  logic [31:0]         capacity,
  output logic                s1_valid,
  output hbp_pkg::pack_res_t  res
);

  function automatic logic word_flag(input logic [31:0] w, input logic f);
    logic r;
    r = f;
    if (w == 32'd0) begin
      r = 1'b1;
    end else if (w != hbp_pkg::HIGH_MARK) begin
      r = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [29:0] sat_inc(input logic [29:0] c);
    return (c == '1) ? c : c + 30'd1;
  endfunction

  logic        s1_fin;
  logic [7:0]  s1_sym;
  logic [31:0] bitbuf;
  logic [4:0]  free_bits;
  logic        lsf;
  logic        lwf;
  logic [29:0] wcnt;

  logic        fits;
  logic [31:0] code32;
  logic [31:0] buf_fit;
  logic [31:0] w_enc;
  logic [4:0]  free_spill;
  logic        lsf_enc;
  logic        full;
  logic [31:0] wf0;
  logic        fin_emit;
  logic        second;
  logic [29:0] cnt1;
  logic [29:0] cnt2;
  logic [29:0] cnt_fin;
  logic [31:0] bytes;
  logic        ovf;

  always_comb begin
    code32     = {24'd0, rd_data.code};
    fits       = rd_data.len <= free_bits;
    buf_fit    = (bitbuf << rd_data.len) | code32;
    w_enc      = (bitbuf << free_bits) | (code32 >> 5'(rd_data.len - free_bits));
    free_spill = 5'(6'({1'b0, free_bits} + 6'd32) - {1'b0, rd_data.len});
    if (s1_sym == zero_sym) begin
      lsf_enc = 1'b1;
    end else if (s1_sym != one_sym) begin
      lsf_enc = 1'b0;
    end else begin
      lsf_enc = lsf;
    end

    full = free_bits == 5'd0;
    if (full) begin
      wf0 = bitbuf;
    end else if (lsf) begin
      wf0 = (bitbuf << free_bits) | (32'd1 << 5'(free_bits - 5'd1));
    end else begin
      wf0 = bitbuf << free_bits;
    end
    fin_emit = full | lsf | (bitbuf != 32'd0);
    second   = full & (lsf ^ word_flag(bitbuf, lwf));
    cnt1     = sat_inc(wcnt);
    cnt2     = sat_inc(cnt1);
    if (second) begin
      cnt_fin = cnt2;
    end else if (fin_emit) begin
      cnt_fin = cnt1;
    end else begin
      cnt_fin = wcnt;
    end
    bytes = {cnt_fin, 2'b00};
    ovf   = bytes > capacity;
  end

  // result words of the item in this stage
  always_comb begin
    res    = '0;
    res.n  = 2'd0;
    if (s1_fin) begin
      if (!fin_emit) begin
        res.n  = 2'd1;
        res.r0 = '{out_word: 32'd0, word_valid: 1'b0, last: 1'b1,
                   total_bytes: bytes, overflow: ovf};
      end else if (!second) begin
        res.n  = 2'd1;
        res.r0 = '{out_word: wf0, word_valid: 1'b1, last: 1'b1,
                   total_bytes: bytes, overflow: ovf};
      end else begin
        res.n  = 2'd2;
        res.r0 = '{out_word: wf0, word_valid: 1'b1, last: 1'b0,
                   total_bytes: 32'd0, overflow: 1'b0};
        res.r1 = '{out_word: hbp_pkg::HIGH_MARK, word_valid: 1'b1, last: 1'b1,
                   total_bytes: bytes, overflow: ovf};
      end
    end else if (!fits) begin
      res.n  = 2'd1;
      res.r0 = '{out_word: w_enc, word_valid: 1'b1, last: 1'b0,
                 total_bytes: 32'd0, overflow: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_fin <= in_fin;
      s1_sym <= in_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitbuf    <= 32'd0;
      free_bits <= hbp_pkg::FIRST_FREE;
      lsf       <= 1'b1;
      lwf       <= 1'b1;
      wcnt      <= 30'd0;
    end else if (adv) begin
      if (s1_fin) begin
        // stream done, back to start of stream
        bitbuf    <= 32'd0;
        free_bits <= hbp_pkg::FIRST_FREE;
        lsf       <= 1'b1;
        lwf       <= 1'b1;
        wcnt      <= 30'd0;
      end else begin
        lsf <= lsf_enc;
        if (fits) begin
          bitbuf    <= buf_fit;
          free_bits <= free_bits - rd_data.len;
        end else begin
          bitbuf    <= code32;
          free_bits <= free_spill;
          lwf       <= word_flag(w_enc, lwf);
          wcnt      <= cnt1;
        end
      end
    end
  end

  `HBP_ASSERT_NEXT(a_fin_restart, clk, rst, adv && s1_fin,
    free_bits == hbp_pkg::FIRST_FREE && wcnt == 30'd0 && bitbuf == 32'd0,
    "finish did not restart the stream")
  `HBP_ASSERT(a_enc_single, clk, rst, !(s1_valid && !s1_fin) || res.n != 2'd2,
    "encode produced two words")
  `HBP_ASSERT(a_bare_on_fin, clk, rst,
    !(res.n != 2'd0 && !res.r0.word_valid) || (s1_fin && res.r0.last),
    "bare report outside finish")

endmodule

// ===== rtl/hbp_out_fifo.sv =====
// result queue taking up to two results a cycle
`include "huffman_bit_packer_assert.svh"

module hbp_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  hbp_pkg::pack_res_t push,
  input  logic               pop_ready,
  output logic               out_valid,
  output hbp_pkg::result_t   out_data,
  output logic               room
);

  hbp_pkg::result_t mem [hbp_pkg::OUT_DEPTH];

  logic [hbp_pkg::OUT_PTR_W-1:0] rp;
  logic [hbp_pkg::OUT_PTR_W-1:0] wp;
  logic [hbp_pkg::OUT_CNT_W-1:0] cnt;
  logic                          pop;

  assign out_valid = cnt != '0;
  assign out_data  = mem[rp];
  assign pop       = pop_ready & out_valid;
  // two free slots are needed for the worst case finish
  assign room      = cnt <= hbp_pkg::OUT_CNT_W'(hbp_pkg::OUT_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wp] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[hbp_pkg::OUT_PTR_W'(wp + 1'b1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp  <= '0;
      wp  <= '0;
      cnt <= '0;
    end else begin
      rp  <= rp + hbp_pkg::OUT_PTR_W'(pop);
      wp  <= wp + hbp_pkg::OUT_PTR_W'(push.n);
      cnt <= cnt + hbp_pkg::OUT_CNT_W'(push.n) - hbp_pkg::OUT_CNT_W'(pop);
    end
  end

  `HBP_ASSERT(a_cnt_bound, clk, rst, cnt <= hbp_pkg::OUT_CNT_W'(hbp_pkg::OUT_DEPTH),
    "result queue count out of range")
  `HBP_ASSERT(a_push_room, clk, rst, push.n == 2'd0 || room,
    "push into result queue without room")
  `HBP_ASSERT_NEXT(a_cnt_track, clk, rst, 1'b1,
    cnt == hbp_pkg::OUT_CNT_W'($past(cnt) + hbp_pkg::OUT_CNT_W'($past(push.n))
                               - hbp_pkg::OUT_CNT_W'($past(pop))),
    "result queue count mismatch")

endmodule

// ===== rtl/huffman_bit_packer.sv =====
// top level of the huffman bit packer
//
// channel  | dir | handshake              | payload
// s_axis   | in  | tvalid/tready          | tuser action, tdata symbol/length/code
// m_axis   | out | tvalid/tready, tlast   | tuser word_valid, tdata word/bytes/overflow
// cfg      | in  | cfg_wen (no wait)      | cfg_index, cfg_data
//
// one request per cycle sustained: a request is registered with its table
// read into the packing stage, which owns the bit buffer and counters
// results queue in a four-entry buffer; a finish may emit two words, drained
// one per cycle, and the input stalls while fewer than two slots are free
// reset is synchronous; the code table has no reset and no clearing pass
module huffman_bit_packer #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // symbol[7:0], entry_length[12:8], entry_code[20:13]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_word[31:0], total_bytes[63:32], overflow[64]
  output logic        m_axis_tuser,   // word_valid
  output logic        m_axis_tlast,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // configuration registers
  logic [7:0]  zero_sym;
  logic [7:0]  one_sym;
  logic [31:0] capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_sym <= 8'd0;
      one_sym  <= 8'd0;
      capacity <= 32'hFFFF_FFFF;
    end else if (cfg_wen) begin
      case (cfg_index)
        hbp_pkg::REG_ZERO_SYM: zero_sym <= cfg_data[7:0];
        hbp_pkg::REG_ONE_SYM:  one_sym  <= cfg_data[7:0];
        hbp_pkg::REG_CAPACITY: capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // input request decode
  logic [7:0]          in_sym;
  hbp_pkg::tbl_entry_t in_entry;
  logic                is_load;
  logic                is_enc;
  logic                is_fin;
  logic                in_range;
  logic                accept;
  logic                take;

  assign in_sym        = s_axis_tdata[7:0];
  assign in_entry.len  = s_axis_tdata[12:8];
  assign in_entry.code = s_axis_tdata[20:13];
  assign in_range      = {1'b0, in_sym} < 9'(SYMBOL_COUNT);

  always_comb begin
    is_load = 1'b0;
    is_enc  = 1'b0;
    is_fin  = 1'b0;
    case (hbp_pkg::action_t'(s_axis_tuser))
      hbp_pkg::ACT_LOAD:   is_load = 1'b1;
      hbp_pkg::ACT_ENCODE: is_enc  = 1'b1;
      hbp_pkg::ACT_FINISH: is_fin  = 1'b1;
      default: ;  // unused code, dropped
    endcase
  end

  // packing stage and result queue handshake
  logic               s1_valid;
  logic               room;
  logic               adv;
  hbp_pkg::pack_res_t res;
  hbp_pkg::pack_res_t push;
  hbp_pkg::tbl_entry_t rd_data;
  hbp_pkg::result_t   out_data;

  assign adv           = s1_valid & room;
  assign s_axis_tready = !s1_valid | room;
  assign accept        = s_axis_tvalid & s_axis_tready;
  // only in-range encodes and finishes enter the packing stage
  assign take          = accept & ((is_enc & in_range) | is_fin);

  always_comb begin
    push = res;
    if (!adv) begin
      push.n = 2'd0;
    end
  end

  // a load writes at its accept edge, so a following encode reads fresh data
  hbp_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .IDX_W        (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (accept & is_load & in_range),
    .wr_idx  (in_sym[IDX_W-1:0]),
    .wr_data (in_entry),
    .rd_en   (accept & is_enc & in_range),
    .rd_idx  (in_sym[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  hbp_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_fin   (is_fin),
    .in_sym   (in_sym),
    .rd_data  (rd_data),
    .adv      (adv),
    .zero_sym (zero_sym),
    .one_sym  (one_sym),
    .capacity (capacity),
    .s1_valid (s1_valid),
    .res      (res)
  );

  hbp_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data),
    .room      (room)
  );

  assign m_axis_tdata = {7'd0, out_data.overflow, out_data.total_bytes, out_data.out_word};
  assign m_axis_tuser = out_data.word_valid;
  assign m_axis_tlast = out_data.last;

endmodule
